### sv/bkc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bkc_pkg: shared types and constants for the keyframe curve player
// Payload structs, command codes and fixed widths.
// ----------------------------------------------------------------------------
package bkc_pkg;

  localparam int MaxKeys  = 32;
  localparam int SlotW    = $clog2(MaxKeys);
  localparam int CountW   = 6;
  localparam int FracBits = 16;
  localparam int TimeW    = 16;
  localparam int ValW     = 32;
  localparam int TW       = FracBits + 1;
  localparam int AccW     = 40;
  localparam int QDepth   = 2;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef struct packed {
    logic                    cmd;
    logic [4:0]              key_slot;
    logic [TimeW-1:0]        key_time;
    logic signed [ValW-1:0]  key_value;
    logic signed [ValW-1:0]  key_out_handle;
    logic signed [ValW-1:0]  key_in_handle;
  } bkc_in_t;

  typedef struct packed {
    logic signed [ValW-1:0]  curve_value;
    logic                    recomputed;
    logic [TimeW-1:0]        frame_now;
    logic [4:0]              segment_now;
  } bkc_out_t;

  // Work handed from the front part to the back part.
  typedef struct packed {
    logic                    eval;     // evaluate the curve
    logic [TimeW-1:0]        d;        // frame - t0
    logic [TimeW-1:0]        span;     // t1 - t0 when positive
    logic [1:0]              tmode;    // 0 divide, 1 t=one, 2 t=zero
    logic signed [ValW-1:0]  p0;
    logic signed [ValW-1:0]  p1;
    logic signed [ValW-1:0]  p2;
    logic signed [ValW-1:0]  p3;
    logic [TimeW-1:0]        frame_now;
    logic [4:0]              segment_now;
  } bkc_job_t;

  localparam logic [1:0] TM_DIV  = 2'd0;
  localparam logic [1:0] TM_ONE  = 2'd1;
  localparam logic [1:0] TM_ZERO = 2'd2;

endpackage
`default_nettype wire

### sv/bkc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bkc_front: request decode, keyframe store and segment tracking
// Loads write the store; ticks step frame and segment; each emits one job.
// ----------------------------------------------------------------------------
module bkc_front (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_we,
  input  wire [5:0]              cfg_wdata,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  bkc_pkg::bkc_in_t       in_data,
  output logic                   job_valid,
  input  wire                    job_stall,
  output bkc_pkg::bkc_job_t      job
);
  import bkc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EMIT = 3'b100
  } fst_t;

  logic [CountW-1:0]       key_count_r;
  logic [TimeW-1:0]        times_mem [MaxKeys];
  logic signed [ValW-1:0]  vals_mem  [MaxKeys];
  logic signed [ValW-1:0]  outh_mem  [MaxKeys];
  logic signed [ValW-1:0]  inh_mem   [MaxKeys];

  fst_t                    st_r;
  logic [TimeW-1:0]        frame_r;
  logic [SlotW-1:0]        seg_r;
  logic                    is_load_r;
  logic [TimeW-1:0]        t0_r, t1_r;
  logic signed [ValW-1:0]  p0_r, p1_r, p2_r, p3_r;
  logic [TimeW-1:0]        fr_r;
  logic [SlotW-1:0]        s_r;
  bkc_job_t                job_r;

  logic [CountW-1:0]       count;
  logic                    accept;
  logic [SlotW-1:0]        s_use;
  logic [CountW-1:0]       n_ext;
  logic [TimeW-1:0]        fr_use;

  assign count    = (key_count_r > CountW'(MaxKeys)) ? CountW'(MaxKeys) : key_count_r;
  assign in_stall = (st_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign job_valid = (st_r == ST_EMIT);
  assign job       = job_r;

  // Restart when the segment went stale after key_count was lowered.
  always_comb begin
    if ({1'b0, seg_r} + CountW'(1) >= count) begin
      s_use  = '0;
      fr_use = TimeW'(1);
    end else begin
      s_use  = seg_r;
      fr_use = frame_r + TimeW'(1);
    end
    n_ext = {1'b0, s_use} + CountW'(1);
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.cmd == CMD_LOAD) begin
      times_mem[in_data.key_slot] <= in_data.key_time;
      vals_mem[in_data.key_slot]  <= in_data.key_value;
      outh_mem[in_data.key_slot]  <= in_data.key_out_handle;
      inh_mem[in_data.key_slot]   <= in_data.key_in_handle;
    end
    if (accept) begin
      t0_r <= times_mem[s_use];
      t1_r <= times_mem[n_ext[SlotW-1:0]];
      p0_r <= vals_mem[s_use];
      p1_r <= outh_mem[s_use];
      p2_r <= inh_mem[n_ext[SlotW-1:0]];
      p3_r <= vals_mem[n_ext[SlotW-1:0]];
      fr_r <= fr_use;
      s_r  <= s_use;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= '0;
      st_r        <= ST_IDLE;
      frame_r     <= '0;
      seg_r       <= '0;
      is_load_r   <= 1'b0;
    end else begin
      if (cfg_we) key_count_r <= cfg_wdata;
      case (st_r)
        ST_IDLE: begin
          if (accept) begin
            is_load_r <= (in_data.cmd == CMD_LOAD) || (count < CountW'(2));
            st_r      <= ST_READ;
          end
        end
        ST_READ: begin
          st_r <= ST_EMIT;
          job_r.eval <= !is_load_r && (fr_r >= t0_r);
          job_r.d    <= fr_r - t0_r;
          job_r.span <= t1_r - t0_r;
          job_r.p0   <= p0_r;
          job_r.p1   <= p1_r;
          job_r.p2   <= p2_r;
          job_r.p3   <= p3_r;
          if (t1_r == t0_r)     job_r.tmode <= TM_ONE;
          else if (t1_r < t0_r) job_r.tmode <= TM_ZERO;
          else                  job_r.tmode <= TM_DIV;
          if (is_load_r) begin
            job_r.frame_now   <= frame_r;
            job_r.segment_now <= seg_r;
          end else if (fr_r >= t0_r) begin
            if (fr_r >= t1_r) begin
              if ({1'b0, s_r} + CountW'(2) >= count) begin
                frame_r <= '0;
                seg_r   <= '0;
                job_r.frame_now   <= '0;
                job_r.segment_now <= '0;
              end else begin
                frame_r <= fr_r;
                seg_r   <= s_r + SlotW'(1);
                job_r.frame_now   <= fr_r;
                job_r.segment_now <= s_r + SlotW'(1);
              end
            end else begin
              frame_r <= fr_r;
              seg_r   <= s_r;
              job_r.frame_now   <= fr_r;
              job_r.segment_now <= s_r;
            end
          end else begin
            frame_r <= fr_r;
            seg_r   <= s_r;
            job_r.frame_now   <= fr_r;
            job_r.segment_now <= s_r;
          end
        end
        ST_EMIT: begin
          if (!job_stall) st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/bkc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bkc_queue: short job queue between front and back
// Two-entry FIFO; each side stalls on its own.
// ----------------------------------------------------------------------------
module bkc_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                wr_valid,
  output logic               wr_stall,
  input  bkc_pkg::bkc_job_t  wr_data,
  output logic               rd_valid,
  input  wire                rd_stall,
  output bkc_pkg::bkc_job_t  rd_data
);
  import bkc_pkg::*;

  bkc_job_t   q_r [QDepth];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_stall = (cnt_r == 2'(QDepth));
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = q_r[rp_r];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

### sv/bkc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bkc_back: curve evaluation
// Serial divide for t if span > 0, then three Horner steps, saturate, hold.
// ----------------------------------------------------------------------------
module bkc_back (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                job_valid,
  output logic               job_stall,
  input  bkc_pkg::bkc_job_t  job,
  output logic               out_valid,
  input  wire                out_stall,
  output bkc_pkg::bkc_out_t  out_data
);
  import bkc_pkg::*;

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_COEF = 6'b000010,
    B_DIV  = 6'b000100,
    B_MUL  = 6'b001000,
    B_ADD  = 6'b010000,
    B_OUT  = 6'b100000
  } bst_t;

  localparam int DivSteps = TimeW + FracBits;
  localparam int StepW    = $clog2(DivSteps + 1);
  localparam int ProdW    = AccW + TW;

  bst_t                    st_r;
  bkc_job_t                j_r;
  logic signed [AccW-1:0]  a_r, b_r, c_r, acc_r;
  logic [1:0]              hstep_r;
  logic [DivSteps-1:0]     num_r;
  logic [TimeW:0]          rem_r;
  logic [DivSteps-1:0]     quo_r;
  logic [StepW-1:0]        dcnt_r;
  logic [TW-1:0]           t_r;
  logic signed [ProdW-1:0] prod_r;
  logic signed [ValW-1:0]  held_r;
  bkc_out_t                out_r;

  logic [TimeW:0]          rem_sh;
  logic signed [AccW-1:0]  e0, e1, e2, e3, ev3;
  logic signed [AccW-1:0]  fl, addend, sum;

  assign job_stall = (st_r != B_IDLE);
  assign out_valid = (st_r == B_OUT);
  assign out_data  = out_r;

  assign e0  = AccW'(j_r.p0);
  assign e1  = AccW'(j_r.p1);
  assign e2  = AccW'(j_r.p2);
  assign e3  = AccW'(j_r.p3);
  assign ev3 = (e1 - e0) + ((e1 - e0) <<< 1);
  assign rem_sh = {rem_r[TimeW-1:0], num_r[DivSteps-1]};
  // Arithmetic shift floors toward minus infinity.
  assign fl  = AccW'(prod_r >>> FracBits);
  always_comb begin
    case (hstep_r)
      2'd0:    addend = b_r;
      2'd1:    addend = c_r;
      default: addend = e0;
    endcase
  end
  assign sum = fl + addend;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= B_IDLE;
      held_r <= '0;
    end else begin
      case (st_r)
        B_IDLE: begin
          if (job_valid) begin
            j_r  <= job;
            st_r <= job.eval ? B_COEF : B_OUT;
            if (!job.eval) begin
              out_r.curve_value <= held_r;
              out_r.recomputed  <= 1'b0;
              out_r.frame_now   <= job.frame_now;
              out_r.segment_now <= job.segment_now;
            end
          end
        end
        B_COEF: begin
          c_r <= ev3;
          b_r <= ((e2 - e1) + ((e2 - e1) <<< 1)) - ev3;
          a_r <= e3 - e0 - ((e2 - e1) + ((e2 - e1) <<< 1));
          num_r  <= {j_r.d, FracBits'(0)};
          rem_r  <= '0;
          quo_r  <= '0;
          dcnt_r <= '0;
          st_r   <= B_DIV;
        end
        B_DIV: begin
          if (j_r.tmode != TM_DIV) begin
            t_r     <= (j_r.tmode == TM_ONE) ? TW'(1) << FracBits : '0;
            acc_r   <= a_r;
            hstep_r <= '0;
            st_r    <= B_MUL;
          end else if (dcnt_r == StepW'(DivSteps)) begin
            t_r     <= (quo_r > DivSteps'(1) << FracBits) ? TW'(1) << FracBits
                                                          : quo_r[TW-1:0];
            acc_r   <= a_r;
            hstep_r <= '0;
            st_r    <= B_MUL;
          end else begin
            // One quotient bit per cycle.
            num_r <= num_r << 1;
            if (rem_sh >= {1'b0, j_r.span}) begin
              rem_r <= rem_sh - {1'b0, j_r.span};
              quo_r <= {quo_r[DivSteps-2:0], 1'b1};
            end else begin
              rem_r <= rem_sh;
              quo_r <= {quo_r[DivSteps-2:0], 1'b0};
            end
            dcnt_r <= dcnt_r + StepW'(1);
          end
        end
        B_MUL: begin
          prod_r <= ProdW'(acc_r) * ProdW'($signed({1'b0, t_r}));
          st_r   <= B_ADD;
        end
        B_ADD: begin
          acc_r <= sum;
          if (hstep_r == 2'd2) begin
            if (sum > AccW'(32'sh7fffffff))      held_r <= 32'sh7fffffff;
            else if (sum < -AccW'(64'sh80000000)) held_r <= 32'sh80000000;
            else                                   held_r <= sum[ValW-1:0];
            if (sum > AccW'(32'sh7fffffff))      out_r.curve_value <= 32'sh7fffffff;
            else if (sum < -AccW'(64'sh80000000)) out_r.curve_value <= 32'sh80000000;
            else                                   out_r.curve_value <= sum[ValW-1:0];
            out_r.recomputed  <= 1'b1;
            out_r.frame_now   <= j_r.frame_now;
            out_r.segment_now <= j_r.segment_now;
            st_r <= B_OUT;
          end else begin
            hstep_r <= hstep_r + 2'd1;
            st_r    <= B_MUL;
          end
        end
        B_OUT: begin
          if (!out_stall) st_r <= B_IDLE;
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/bezier_keyframe_curve_player.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bezier_keyframe_curve_player: cubic Bezier keyframe playback
// Input channel in_valid/in_stall carries load and tick requests; each
// request gives exactly one result on out_valid/out_stall. cfg_we writes
// key_count. A tick that evaluates runs through coefficient setup, the
// bit-serial divider for t and a step to finish it, then three
// multiply/add steps of the Horner unit; with a zero or negative span the
// divider is skipped. The front part (decode, keyframe store, frame and
// segment state) takes a new request only after its job is handed on,
// passes jobs through a two-entry queue, and can accept the next request
// while the back part is still evaluating. Reset clears key_count, frame,
// segment and the held value; the keyframe store is not cleared. A stalled
// result holds on the output and back-pressure reaches the input once the
// queue fills.
// ----------------------------------------------------------------------------
module bezier_keyframe_curve_player (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire [5:0]          cfg_wdata,
  input  wire                in_valid,
  output logic               in_stall,
  input  bkc_pkg::bkc_in_t   in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output bkc_pkg::bkc_out_t  out_data
);
  import bkc_pkg::*;

  bkc_job_t fj, qj;
  logic     fj_valid, fj_stall, qj_valid, qj_stall;

  bkc_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_valid, .in_stall, .in_data,
    .job_valid(fj_valid), .job_stall(fj_stall), .job(fj)
  );

  bkc_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fj_valid), .wr_stall(fj_stall), .wr_data(fj),
    .rd_valid(qj_valid), .rd_stall(qj_stall), .rd_data(qj)
  );

  bkc_back u_back (
    .clk, .rst_n,
    .job_valid(qj_valid), .job_stall(qj_stall), .job(qj),
    .out_valid, .out_stall, .out_data
  );

endmodule
`default_nettype wire

### sv/bkc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bkc_checker: port-level checks for the curve player
// Watches handshakes and result fields over time.
// ----------------------------------------------------------------------------
module bkc_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_stall,
  input wire                out_valid,
  input wire                out_stall,
  input bkc_pkg::bkc_out_t  out_data
);
  import bkc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("two results accepted in consecutive cycles");

  a_reset_out: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result right after reset");

  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("two requests accepted in consecutive cycles");

endmodule

bind bezier_keyframe_curve_player bkc_checker u_bkc_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the keyframe curve player
// Loads keyframe slots, plays ticks under several key counts and checks each
// result against a fixed-point curve predictor, with random idling on both
// sides and one long back-pressure stretch.
// ----------------------------------------------------------------------------
import bkc_pkg::*;

class curve_scoreboard;
  bkc_out_t                 pending[$];
  int                       mismatches;
  logic [5:0]               count_reg;
  logic [TimeW-1:0]         times[MaxKeys];
  logic signed [ValW-1:0]   vals[MaxKeys];
  logic signed [ValW-1:0]   outh[MaxKeys];
  logic signed [ValW-1:0]   inh[MaxKeys];
  logic [TimeW-1:0]         frame;
  logic [4:0]               seg;
  logic signed [ValW-1:0]   held;

  function new();
    mismatches = 0;
    count_reg = 0;
    frame = 0;
    seg = 0;
    held = 0;
    for (int i = 0; i < MaxKeys; i++) begin
      times[i] = 0; vals[i] = 0; outh[i] = 0; inh[i] = 0;
    end
  endfunction

  function longint floor_shift(longint x);
    return x >>> FracBits;
  endfunction

  function logic signed [ValW-1:0] bezier(longint p0, longint p1, longint p2,
                                           longint p3, longint t);
    longint c, b, a, acc;
    c = 3 * (p1 - p0);
    b = 3 * (p2 - p1) - c;
    a = p3 - p0 - c - b;
    acc = floor_shift(a * t) + b;
    acc = floor_shift(acc * t) + c;
    acc = floor_shift(acc * t) + p0;
    if (acc > 64'sh7fffffff) acc = 64'sh7fffffff;
    if (acc < -64'sh80000000) acc = -64'sh80000000;
    return acc[31:0];
  endfunction

  function void note_request(bkc_in_t req);
    bkc_out_t r;
    int cnt, n;
    longint span, t, q;
    logic rec;
    rec = 0;
    if (req.cmd == CMD_LOAD) begin
      times[req.key_slot] = req.key_time;
      vals[req.key_slot] = req.key_value;
      outh[req.key_slot] = req.key_out_handle;
      inh[req.key_slot] = req.key_in_handle;
    end else begin
      cnt = (count_reg > MaxKeys) ? MaxKeys : count_reg;
      if (cnt >= 2) begin
        if (seg + 1 >= cnt) begin
          frame = 0; seg = 0;
        end
        n = seg + 1;
        frame = frame + 1;
        if (frame >= times[seg]) begin
          span = longint'(times[n]) - longint'(times[seg]);
          if (span == 0) t = 1 << FracBits;
          else if (span < 0) t = 0;
          else begin
            q = (longint'(frame - times[seg]) << FracBits) / span;
            t = (q > (1 << FracBits)) ? (1 << FracBits) : q;
          end
          held = bezier(vals[seg], outh[seg], inh[n], vals[n], t);
          rec = 1;
          if (frame >= times[n]) begin
            seg = 5'(n);
            if (n + 1 >= cnt) begin
              frame = 0; seg = 0;
            end
          end
        end
      end
    end
    r.curve_value = held;
    r.recomputed = rec;
    r.frame_now = frame;
    r.segment_now = seg;
    pending.push_back(r);
  endfunction

  function void check_result(bkc_out_t got);
    bkc_out_t exp_r;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %p", got);
      return;
    end
    exp_r = pending.pop_front();
    if (got.curve_value !== exp_r.curve_value || got.recomputed !== exp_r.recomputed ||
        got.frame_now !== exp_r.frame_now || got.segment_now !== exp_r.segment_now) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected %p actual %p", exp_r, got);
    end
  endfunction
endclass

module tb_top;
  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [5:0] cfg_wdata = 0;
  logic in_valid = 0;
  logic in_stall;
  bkc_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  bkc_out_t out_data;

  curve_scoreboard sb = new();
  int idle_pct = 19;
  bit hold_off = 0;
  int quiet = 0;

  bezier_keyframe_curve_player i_dut (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Receiver: random stall, forced during a hold-off.
  always @(posedge clk) begin
    if (out_valid && !out_stall && rst_n) sb.check_result(out_data);
    out_stall <= hold_off || ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("[bezier_keyframe_curve_player] ERROR");
      $finish;
    end
  end

  // Valid stays high after an accept until the next request or idle drops it.
  task automatic send(bkc_in_t req);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
  endtask

  task automatic load(int slot, int tm, int v, int o, int i);
    bkc_in_t r;
    r.cmd = CMD_LOAD;
    r.key_slot = 5'(slot);
    r.key_time = TimeW'(tm);
    r.key_value = v;
    r.key_out_handle = o;
    r.key_in_handle = i;
    send(r);
  endtask

  task automatic tick();
    bkc_in_t r;
    r = bkc_in_t'($bits(bkc_in_t)'({$urandom, $urandom, $urandom, $urandom}));
    r.cmd = CMD_TICK;
    send(r);
  endtask

  task automatic set_count(int c);
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= 6'(c);
    sb.count_reg = 6'(c);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_keys(int cnt, int step);
    int tm;
    tm = $urandom_range(3);
    for (int k = 0; k < cnt; k++) begin
      load(k, tm, $urandom, $urandom, $urandom);
      tm += $urandom_range(step);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: too few keys, extremes, zero and negative span.
    tick();
    load(0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    load(1, 3, 32'h80000000, 32'h7fffffff, 32'h80000000);
    load(2, 3, 32'h00010000, 32'hffffffff, 32'h0);
    load(3, 1, 32'h0, 32'h12345678, 32'hedcba987);
    load(31, 16'hffff, 32'h5, 32'h6, 32'h7);
    tick();
    set_count(1);
    tick();
    set_count(4);
    repeat (12) tick();
    set_count(2);
    repeat (3) tick();
    // Before start time: first key later than frame 1.
    load(0, 5, 32'h10000, 32'h20000, 32'h30000);
    repeat (6) tick();
    // Zero-span segment with the whole store, exercise large count.
    for (int k = 0; k < MaxKeys; k++)
      load(k, 16'hfff0 + k / 4, $urandom, $urandom, $urandom);
    set_count(63);
    // Frame wrap: many ticks toward 0xfff0 would be long; just a few here.
    repeat (20) tick();
    set_count(32);
    repeat (10) tick();
    // Random phases.
    for (int ph = 0; ph < 6; ph++) begin
      int cnt;
      cnt = (ph == 0) ? 2 : (ph == 5) ? 32 : $urandom_range(2, 8);
      idle_pct = (ph == 2) ? 0 : 19;
      set_count(0);
      random_keys(cnt, (ph == 3) ? 2 : 12);
      set_count(cnt + ((ph == 4) ? 20 : 0));
      if (ph == 1) begin
        fork
          begin
            hold_off = 1;
            repeat (300) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      for (int j = 0; j < 180; j++) begin
        if ($urandom_range(99) < 8)
          load($urandom_range(cnt - 1), $urandom_range(60), $urandom, $urandom, $urandom);
        else tick();
      end
    end
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0) $display("[bezier_keyframe_curve_player] OK");
    else $display("[bezier_keyframe_curve_player] ERROR");
    $finish;
  end
endmodule
